FILE: rtl/core/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and codes for the DDA line rasteriser core: request and
// response payloads, operation codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package dda_pkg;

	localparam int FIELD_W = 12;
	localparam int PIX_W   = 12;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} dda_op_t;

	typedef struct packed {
		dda_op_t              op;
		logic [FIELD_W-1:0]   x_start;
		logic [FIELD_W-1:0]   y_start;
		logic [FIELD_W-1:0]   x_end;
		logic [FIELD_W-1:0]   y_end;
	} dda_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic             pixel_valid;
		logic             last;
	} dda_rsp_t;

	typedef enum logic [1:0] {
		SEQ_IDLE  = 2'd0,
		SEQ_DIV_X = 2'd1,
		SEQ_DIV_Y = 2'd2
	} dda_seq_t;

endpackage

FILE: rtl/core/dda_line_rasterizer_core.sv
// A step request's response is registered and appears in the cycle after acceptance.
// Step requests are taken one per cycle while the response register drains and no division runs.
// A load with a nonzero length holds the request side while one shared
// compare/subtract unit divides both axes in turn, x first and then y.
// Reset (arst_n low, asynchronous) leaves no line pending and the response register empty.
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core
// Digital differential analyser line rasteriser. A load request captures a
// line and computes per-axis fixed-point increments by restoring division;
// each step request returns the current pixel and advances the position, or an empty response once the line is done.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  dda_pkg::dda_req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dda_pkg::dda_rsp_t rsp
);
	import dda_pkg::*;

	localparam int POS_W = COORD_BITS + FRAC_BITS;
	localparam int INC_W = FRAC_BITS + 2;
	localparam int QUO_W = FRAC_BITS + 1;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	// line state
	logic [POS_W-1:0]      pos_x_q, pos_y_q;
	logic [INC_W-1:0]      inc_x_q, inc_y_q;
	logic [COORD_BITS-1:0] remaining_q;

	// divider state
	dda_seq_t              state_q, state_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [COORD_BITS-1:0] rem_q, mag_x_q, mag_y_q, divisor_q;
	logic [FRAC_BITS-1:0]  quo_q;
	logic                  neg_x_q, neg_y_q;
	logic                  div_step, wr_inc_x, wr_inc_y;

	// response register
	logic                  rsp_valid_q;
	dda_rsp_t              rsp_q;

	// request decode
	logic                  req_acc, is_load, is_step, has_pix;
	logic [COORD_BITS-1:0] xs_w, ys_w, xe_w, ye_w, adx_w, ady_w, step_w;
	logic                  neg_x_w, neg_y_w;

	// shared compare/subtract unit
	logic [COORD_BITS-1:0] mag_sel, rem_next;
	logic [COORD_BITS:0]   trial, diff;
	logic                  ge, neg_sel, div_done;
	logic [QUO_W-1:0]      quo_full;
	logic [INC_W-1:0]      inc_new;

	assign req_stall = (state_q != SEQ_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_acc   = req_valid && !req_stall;
	assign is_load   = req_acc && (req.op == OP_LOAD);
	assign is_step   = req_acc && (req.op == OP_STEP);
	assign has_pix   = (remaining_q != '0);

	assign xs_w    = COORD_BITS'(req.x_start);
	assign ys_w    = COORD_BITS'(req.y_start);
	assign xe_w    = COORD_BITS'(req.x_end);
	assign ye_w    = COORD_BITS'(req.y_end);
	assign neg_x_w = (xe_w < xs_w);
	assign neg_y_w = (ye_w < ys_w);
	assign adx_w   = neg_x_w ? (xs_w - xe_w) : (xe_w - xs_w);
	assign ady_w   = neg_y_w ? (ys_w - ye_w) : (ye_w - ys_w);
	assign step_w  = (adx_w > ady_w) ? adx_w : ady_w;

	// One quotient bit per cycle; the first trial takes the magnitude itself,
	// since it never exceeds the divisor.
	assign mag_sel  = (state_q == SEQ_DIV_Y) ? mag_y_q : mag_x_q;
	assign neg_sel  = (state_q == SEQ_DIV_Y) ? neg_y_q : neg_x_q;
	assign trial    = (cnt_q == '0) ? {1'b0, mag_sel} : {rem_q, 1'b0};
	assign diff     = trial - {1'b0, divisor_q};
	assign ge       = (trial >= {1'b0, divisor_q});
	assign rem_next = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
	assign quo_full = {quo_q, ge};
	assign inc_new  = neg_sel ? (INC_W'(0) - {1'b0, quo_full}) : {1'b0, quo_full};
	assign div_done = (cnt_q == CNT_W'(FRAC_BITS));

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		div_step = 1'b0;
		wr_inc_x = 1'b0;
		wr_inc_y = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				cnt_d = '0;
				if (is_load && (step_w != '0)) begin
					state_d = SEQ_DIV_X;
				end
			end
			SEQ_DIV_X: begin
				div_step = 1'b1;
				if (div_done) begin
					wr_inc_x = 1'b1;
					cnt_d    = '0;
					state_d  = SEQ_DIV_Y;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			SEQ_DIV_Y: begin
				div_step = 1'b1;
				if (div_done) begin
					wr_inc_y = 1'b1;
					cnt_d    = '0;
					state_d  = SEQ_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			cnt_q       <= '0;
			remaining_q <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			inc_x_q     <= '0;
			inc_y_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (is_load) begin
				pos_x_q     <= {xs_w, {FRAC_BITS{1'b0}}};
				pos_y_q     <= {ys_w, {FRAC_BITS{1'b0}}};
				inc_x_q     <= '0;
				inc_y_q     <= '0;
				remaining_q <= step_w;
			end else if (is_step && has_pix) begin
				pos_x_q     <= pos_x_q + {{(POS_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
				pos_y_q     <= pos_y_q + {{(POS_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
				remaining_q <= remaining_q - 1'b1;
			end
			if (wr_inc_x) begin
				inc_x_q <= inc_new;
			end
			if (wr_inc_y) begin
				inc_y_q <= inc_new;
			end
			if (is_step) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers: no reset needed
	always_ff @(posedge clk) begin
		if (is_load) begin
			mag_x_q   <= adx_w;
			mag_y_q   <= ady_w;
			neg_x_q   <= neg_x_w;
			neg_y_q   <= neg_y_w;
			divisor_q <= step_w;
		end
		if (div_step) begin
			rem_q <= rem_next;
			if (!div_done) begin
				quo_q <= {quo_q[FRAC_BITS-2:0], ge};
			end
		end
		if (is_step) begin
			rsp_q.pixel_valid <= has_pix;
			rsp_q.last        <= has_pix && (remaining_q == COORD_BITS'(1));
			rsp_q.pixel_x     <= has_pix ? PIX_W'(pos_x_q[POS_W-1:FRAC_BITS]) : '0;
			rsp_q.pixel_y     <= has_pix ? PIX_W'(pos_y_q[POS_W-1:FRAC_BITS]) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRAC_BITS))
		else $error("divider count out of range");

	a_load_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(is_load && (step_w != '0)) |=> (state_q == SEQ_DIV_X))
		else $error("nonzero load did not start the divider");

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != SEQ_IDLE) |-> !req_acc)
		else $error("request accepted while dividing");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(is_step && (remaining_q == COORD_BITS'(1))) |=> (remaining_q == '0))
		else $error("line did not end after its last pixel");

	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.last) |-> rsp_q.pixel_valid)
		else $error("last flagged on an empty response");

endmodule

FILE: test/dda_line_rasterizer_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core_checker
// Watches the request and response channels of the rasteriser core, keeps its
// own copy of the line state, predicts the pixel for every step request and
// compares each response with the oldest predicted pixel, field by field.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  dda_pkg::dda_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  dda_pkg::dda_rsp_t rsp,
	output int                fail_count,
	output int                outstanding,
	output int                pixels_drawn,
	output int                empty_steps
);
	import dda_pkg::*;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int POS_W      = COORD_BITS + FRAC_BITS;
	localparam int INC_W      = FRAC_BITS + 2;
	localparam int PRINT_CAP  = 40;

	logic [POS_W-1:0]      line_x;
	logic [POS_W-1:0]      line_y;
	logic [INC_W-1:0]      slope_x;
	logic [INC_W-1:0]      slope_y;
	logic [COORD_BITS-1:0] pixels_left;
	dda_rsp_t              pixels_due[$];

	// Per-axis increment: magnitude divided by the major span, truncated,
	// then negated for a falling axis.
	function automatic logic [INC_W-1:0] axis_slope(input logic [COORD_BITS-1:0] a_start,
			input logic [COORD_BITS-1:0] a_end, input logic [COORD_BITS-1:0] span);
		logic [31:0] mag;
		logic [31:0] quot;
		mag  = 32'((a_end >= a_start) ? a_end - a_start : a_start - a_end);
		quot = (mag << FRAC_BITS) / {20'b0, span};
		if (a_end < a_start) begin
			quot = -quot;
		end
		return quot[INC_W-1:0];
	endfunction

	task automatic trace_request(input dda_req_t r);
		dda_rsp_t              pix;
		logic [COORD_BITS-1:0] adx;
		logic [COORD_BITS-1:0] ady;
		logic [COORD_BITS-1:0] span;
		if (r.op == OP_LOAD) begin
			adx  = (r.x_end >= r.x_start) ? r.x_end - r.x_start : r.x_start - r.x_end;
			ady  = (r.y_end >= r.y_start) ? r.y_end - r.y_start : r.y_start - r.y_end;
			span = (adx > ady) ? adx : ady;
			line_x = {r.x_start, {FRAC_BITS{1'b0}}};
			line_y = {r.y_start, {FRAC_BITS{1'b0}}};
			if (span == '0) begin
				slope_x = '0;
				slope_y = '0;
			end else begin
				slope_x = axis_slope(r.x_start, r.x_end, span);
				slope_y = axis_slope(r.y_start, r.y_end, span);
			end
			pixels_left = span;
		end else begin
			pix = '0;
			if (pixels_left != '0) begin
				pix.pixel_x     = line_x[POS_W-1 -: PIX_W];
				pix.pixel_y     = line_y[POS_W-1 -: PIX_W];
				pix.pixel_valid = 1'b1;
				pix.last        = (pixels_left == COORD_BITS'(1));
				line_x = line_x + {{(POS_W-INC_W){slope_x[INC_W-1]}}, slope_x};
				line_y = line_y + {{(POS_W-INC_W){slope_y[INC_W-1]}}, slope_y};
				pixels_left = pixels_left - 1'b1;
			end
			pixels_due.push_back(pix);
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		if (fail_count < PRINT_CAP) begin
			$display("%0d ns: %s mismatch, expected %0d, got %0d", $time, what,
				want, got);
		end
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dda_rsp_t due;
		if (!arst_n) begin
			line_x       = '0;
			line_y       = '0;
			slope_x      = '0;
			slope_y      = '0;
			pixels_left  = '0;
			pixels_due.delete();
			fail_count   = 0;
			pixels_drawn = 0;
			empty_steps  = 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pixels_due.size() == 0) begin
					report_mismatch("unrequested response pixel_valid", 0,
						32'(rsp.pixel_valid));
				end else begin
					due = pixels_due.pop_front();
					if (rsp.pixel_x !== due.pixel_x)
						report_mismatch("pixel_x", 32'(due.pixel_x), 32'(rsp.pixel_x));
					if (rsp.pixel_y !== due.pixel_y)
						report_mismatch("pixel_y", 32'(due.pixel_y), 32'(rsp.pixel_y));
					if (rsp.pixel_valid !== due.pixel_valid)
						report_mismatch("pixel_valid", 32'(due.pixel_valid),
							32'(rsp.pixel_valid));
					if (rsp.last !== due.last)
						report_mismatch("last", 32'(due.last), 32'(rsp.last));
					if (due.pixel_valid)
						pixels_drawn++;
					else
						empty_steps++;
				end
			end
			if (req_valid && !req_stall) begin
				trace_request(req);
			end
			outstanding <= pixels_due.size();
		end
	end

endmodule

FILE: test/dda_line_rasterizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core_tb
// Drives load and step requests into the rasteriser core with random gaps and
// response back-pressure; a separate checker predicts and compares the pixels.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core_tb;
	import dda_pkg::*;

	localparam int ITEMS          = 1900;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 50;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	dda_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	dda_rsp_t rsp;

	int fail_count;
	int outstanding;
	int pixels_drawn;
	int empty_steps;

	bit calm         = 1'b0;
	int sent         = 0;
	int loads_sent   = 0;
	int steps_sent   = 0;
	int quiet_cycles = 0;

	dda_line_rasterizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	dda_line_rasterizer_core_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.pixels_drawn (pixels_drawn),
		.empty_steps  (empty_steps)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 17);
	end

	// Hold the payload until the request is taken.
	task automatic send(input dda_req_t r);
		while (!calm && $urandom_range(99) < 17) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sent++;
		if (r.op == OP_LOAD)
			loads_sent++;
		else
			steps_sent++;
	endtask

	task automatic load_line(input int xs, input int ys, input int xe, input int ye);
		dda_req_t r;
		r.op      = OP_LOAD;
		r.x_start = FIELD_W'(xs);
		r.y_start = FIELD_W'(ys);
		r.x_end   = FIELD_W'(xe);
		r.y_end   = FIELD_W'(ye);
		send(r);
	endtask

	// Coordinates on a step request are don't-care; randomise them anyway.
	task automatic step_pixels(input int n);
		dda_req_t r;
		repeat (n) begin
			r.op      = OP_STEP;
			r.x_start = FIELD_W'($urandom_range(4095));
			r.y_start = FIELD_W'($urandom_range(4095));
			r.x_end   = FIELD_W'($urandom_range(4095));
			r.y_end   = FIELD_W'($urandom_range(4095));
			send(r);
		end
	endtask

	task automatic wait_for_pixels();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_line();
		int kind;
		int span;
		int dx;
		int dy;
		int lo;
		int xs;
		int ys;
		int xe;
		int ye;
		int n;
		kind = $urandom_range(99);
		if (kind < 8) begin
			// unconstrained endpoints, usually cut short
			xs = $urandom_range(4095);
			ys = $urandom_range(4095);
			xe = $urandom_range(4095);
			ye = $urandom_range(4095);
			n  = $urandom_range(30);
		end else begin
			if (kind < 12)
				span = $urandom_range(4095);
			else if (kind < 22)
				span = $urandom_range(300);
			else
				span = $urandom_range(24);
			if ($urandom_range(1)) begin
				dx = span;
				dy = $urandom_range(span);
			end else begin
				dx = $urandom_range(span);
				dy = span;
			end
			lo = $urandom_range(4095 - dx);
			if ($urandom_range(1)) begin
				xs = lo;
				xe = lo + dx;
			end else begin
				xs = lo + dx;
				xe = lo;
			end
			lo = $urandom_range(4095 - dy);
			if ($urandom_range(1)) begin
				ys = lo;
				ye = lo + dy;
			end else begin
				ys = lo + dy;
				ye = lo;
			end
			if (span > 40)
				n = $urandom_range(1, 40);
			else if ($urandom_range(99) < 85)
				n = span + $urandom_range(2);
			else
				n = $urandom_range(span);
		end
		load_line(xs, ys, xe, ye);
		step_pixels(n);
	endtask

	initial begin
		bit pressed;
		pressed = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		step_pixels(1);
		load_line(100, 200, 100, 200);
		step_pixels(1);
		load_line(0, 0, 4095, 4095);
		step_pixels(3);
		// replace an unfinished line
		load_line(4095, 0, 0, 4095);
		step_pixels(2);
		load_line(10, 20, 13, 18);
		step_pixels(4);
		load_line(0, 4095, 0, 4094);
		step_pixels(2);
		load_line(4095, 4095, 4090, 0);
		step_pixels(3);
		load_line(1365, 2730, 2730, 1365);
		step_pixels(2);
		wait_for_pixels();

		while (sent < ITEMS) begin
			calm <= (sent >= 700 && sent < 1000);
			random_line();
			if (!pressed && sent >= 1300) begin
				pressed = 1'b1;
				wait_for_pixels();
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d line loads and %0d step requests: %0d pixels drawn, %0d steps idle.",
			loads_sent, steps_sent, pixels_drawn, empty_steps);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Watchdog: no handshake for %0d cycles, %0d pixels still owed.",
			WATCHDOG_LIMIT, outstanding);
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/dda_pkg.sv
rtl/core/dda_line_rasterizer_core.sv
test/dda_line_rasterizer_core_checker.sv
test/dda_line_rasterizer_core_tb.sv
